[hdl/pts_pkg.sv]
// ----------------------------------------------------------------------------
// pts_pkg: shared types and constants for the period to engine speed block
// Widths, limits and the stage record passed along the divider cells.
// ----------------------------------------------------------------------------
package pts_pkg;

  // field widths
  localparam int PERIOD_W = 32;
  localparam int COARSE_W = 16;
  localparam int CYL_W    = 4;
  localparam int RAW_W    = 16;
  localparam int RPM_W    = 13;
  localparam int FINE_W   = 15;

  // divider sizes: quotient bits equal the numerator width
  localparam int QUO_W = 26;
  localparam int REM_W = COARSE_W + CYL_W;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = CYL_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CALC_ENABLE    = 1'b0,
    REG_CYLINDER_COUNT = 1'b1
  } reg_index_t;

  // constants of the speed formula
  localparam logic [QUO_W-1:0]    SPEED_NUMER  = 26'd37500000;
  localparam logic [PERIOD_W-1:0] COARSE_LIMIT = 32'd8388416;
  localparam logic [23:0]         COARSE_HALF  = 24'd64;
  localparam int                  COARSE_SHIFT = 7;
  localparam logic [RAW_W-1:0]    SAT16        = 16'hFFFF;
  localparam logic [RPM_W-1:0]    BDC_MAX      = 13'd8000;
  localparam logic [RPM_W-1:0]    LIMITED_MAX  = 13'd7500;
  localparam logic [FINE_W-1:0]   FINE_MAX     = 15'd32000;
  localparam logic [CYL_W-1:0]    CYL_RESET    = 4'd4;

  // record carried from cell to cell
  typedef struct packed {
    logic [COARSE_W-1:0] coarse;
    logic [REM_W-1:0]    denom;
    logic [REM_W-1:0]    rem;
    logic [QUO_W-1:0]    quo;
  } cell_data_t;

endpackage

[hdl/pts_front.sv]
// ----------------------------------------------------------------------------
// pts_front: configuration registers and period rounding
// Rounds the period to 128-tick units, forms the divisor, drops requests
// while computation is disabled.
// ----------------------------------------------------------------------------
module pts_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [pts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pts_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            up_valid,
  output logic                            up_ready,
  input  logic [pts_pkg::PERIOD_W-1:0]    period_ticks,
  output logic                            dn_valid,
  input  logic                            dn_ready,
  output pts_pkg::cell_data_t             dn_data
);
  import pts_pkg::*;

  logic                calc_enable;
  logic [CYL_W-1:0]    cylinder_count;
  logic [23:0]         period_sum;
  logic [COARSE_W-1:0] coarse_c;
  logic [REM_W-1:0]    denom_c;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      calc_enable    <= 1'b1;
      cylinder_count <= CYL_RESET;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_CALC_ENABLE:    calc_enable    <= cfg_data[0];
        REG_CYLINDER_COUNT: cylinder_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // round to 128-tick units, saturate long periods
  always_comb begin
    period_sum = period_ticks[23:0] + COARSE_HALF;
    if (period_ticks <= COARSE_LIMIT) begin
      coarse_c = period_sum[COARSE_SHIFT +: COARSE_W];
    end else begin
      coarse_c = SAT16;
    end
    denom_c = REM_W'({{CYL_W{1'b0}}, coarse_c} * {{COARSE_W{1'b0}}, cylinder_count});
  end

  // stage register
  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid && calc_enable;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data.coarse <= coarse_c;
      dn_data.denom  <= denom_c;
      dn_data.rem    <= '0;
      dn_data.quo    <= '0;
    end
  end

endmodule

[hdl/pts_cell.sv]
// ----------------------------------------------------------------------------
// pts_cell: one restoring division step
// Shifts one numerator bit into the partial remainder, subtracts the divisor
// when it fits and appends one quotient bit.
// ----------------------------------------------------------------------------
module pts_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 num_bit,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  pts_pkg::cell_data_t  up_data,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output pts_pkg::cell_data_t  dn_data
);
  import pts_pkg::*;

  logic [REM_W:0]   trial;
  logic [REM_W:0]   diff;
  logic             fits;
  cell_data_t       step_c;

  // trial subtraction
  always_comb begin
    trial  = {up_data.rem, num_bit};
    diff   = trial - {1'b0, up_data.denom};
    fits   = trial >= {1'b0, up_data.denom};
    step_c = up_data;
    step_c.rem = fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
    step_c.quo = {up_data.quo[QUO_W-2:0], fits};
  end

  // stage register, holds while downstream stalls
  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= step_c;
    end
  end

endmodule

[hdl/pts_back.sv]
// ----------------------------------------------------------------------------
// pts_back: speed derivation and output register
// Saturates the quotient and forms the rpm, clamped and fine speeds.
// ----------------------------------------------------------------------------
module pts_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  pts_pkg::cell_data_t           up_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pts_pkg::COARSE_W-1:0]  period_coarse,
  output logic [pts_pkg::RAW_W-1:0]     speed_raw,
  output logic [pts_pkg::RPM_W-1:0]     speed_rpm,
  output logic [pts_pkg::RPM_W-1:0]     speed_bdc,
  output logic [pts_pkg::FINE_W-1:0]    speed_fine,
  output logic [pts_pkg::RPM_W-1:0]     speed_limited
);
  import pts_pkg::*;

  logic [RAW_W-1:0]  raw_c;
  logic [RPM_W-1:0]  rpm_c;
  logic [RPM_W-1:0]  bdc_c;
  logic [RPM_W-1:0]  lim_c;
  logic [FINE_W-1:0] half_c;
  logic [FINE_W-1:0] fine_c;

  // saturate quotient, zero divisor gives zero speed
  always_comb begin
    if (up_data.denom == '0) begin
      raw_c = '0;
    end else if (|up_data.quo[QUO_W-1:RAW_W]) begin
      raw_c = SAT16;
    end else begin
      raw_c = up_data.quo[RAW_W-1:0];
    end
    rpm_c  = raw_c[RAW_W-1:3];
    bdc_c  = (rpm_c > BDC_MAX) ? BDC_MAX : rpm_c;
    lim_c  = (rpm_c > LIMITED_MAX) ? LIMITED_MAX : rpm_c;
    half_c = raw_c[RAW_W-1:1];
    fine_c = (half_c > FINE_MAX) ? FINE_MAX : half_c;
  end

  // output register
  assign up_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (up_ready) begin
      out_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      period_coarse <= up_data.coarse;
      speed_raw     <= raw_c;
      speed_rpm     <= rpm_c;
      speed_bdc     <= bdc_c;
      speed_fine    <= fine_c;
      speed_limited <= lim_c;
    end
  end

`ifndef ASSERT_OFF
  a_clamp_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (speed_limited <= speed_bdc) && (speed_bdc <= speed_rpm))
    else $error("clamped speeds out of order");
`endif

endmodule

[hdl/period_to_engine_speed.sv]
// ----------------------------------------------------------------------------
// period_to_engine_speed: engine speed from the captured period
// Converts one period per bottom-dead-centre event into speed values.
// ----------------------------------------------------------------------------
// Usage
//   Input channel in_valid/in_ready carries period_ticks. Output channel
//   out_valid/out_ready carries period_coarse and the five speed values.
//   The config port writes calc_enable (index 0) and cylinder_count
//   (index 1) on cfg_write; write only while no request is in flight.
//   A request taken while calc_enable is clear yields no result.
//   A request loads the rounding stage at the input accept edge, then
//   passes through each of the 26 division cells (one quotient bit each)
//   and then the output register. One request is accepted every cycle
//   while the chain is not backed up by a stalled receiver.
//   Each stage holds its request while the next one is full, so a stalled
//   receiver fills the chain bubble by bubble; in_ready drops only once
//   the first stage is full and blocked. in_ready follows out_ready
//   combinationally through the chain of stage readies.
//   Reset empties the chain and sets calc_enable to 1 and
//   cylinder_count to 4.
// ----------------------------------------------------------------------------
module period_to_engine_speed (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [pts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pts_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [pts_pkg::PERIOD_W-1:0]    period_ticks,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [pts_pkg::COARSE_W-1:0]    period_coarse,
  output logic [pts_pkg::RAW_W-1:0]       speed_raw,
  output logic [pts_pkg::RPM_W-1:0]       speed_rpm,
  output logic [pts_pkg::RPM_W-1:0]       speed_bdc,
  output logic [pts_pkg::FINE_W-1:0]      speed_fine,
  output logic [pts_pkg::RPM_W-1:0]       speed_limited
);
  import pts_pkg::*;

  logic       stage_valid [0:QUO_W];
  logic       stage_ready [0:QUO_W];
  cell_data_t stage_data  [0:QUO_W];

  // rounding and configuration
  pts_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .up_valid     (in_valid),
    .up_ready     (in_ready),
    .period_ticks (period_ticks),
    .dn_valid     (stage_valid[0]),
    .dn_ready     (stage_ready[0]),
    .dn_data      (stage_data[0])
  );

  // division cells, most significant quotient bit first
  for (genvar k = 0; k < QUO_W; k++) begin : g_cell
    pts_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .num_bit  (SPEED_NUMER[QUO_W-1-k]),
      .up_valid (stage_valid[k]),
      .up_ready (stage_ready[k]),
      .up_data  (stage_data[k]),
      .dn_valid (stage_valid[k+1]),
      .dn_ready (stage_ready[k+1]),
      .dn_data  (stage_data[k+1])
    );
  end

  // speed derivation and output register
  pts_back u_back (
    .clk           (clk),
    .rst           (rst),
    .up_valid      (stage_valid[QUO_W]),
    .up_ready      (stage_ready[QUO_W]),
    .up_data       (stage_data[QUO_W]),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .period_coarse (period_coarse),
    .speed_raw     (speed_raw),
    .speed_rpm     (speed_rpm),
    .speed_bdc     (speed_bdc),
    .speed_fine    (speed_fine),
    .speed_limited (speed_limited)
  );

`ifndef ASSERT_OFF
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result present right after reset");

  a_front_free: assert property (@(posedge clk) disable iff (rst)
    !stage_valid[0] |-> in_ready)
    else $error("input blocked while first stage is empty");

  a_zero_period: assert property (@(posedge clk) disable iff (rst)
    out_valid && (period_coarse == '0) |-> (speed_raw == '0) && (speed_fine == '0))
    else $error("nonzero speed for zero coarse period");
`endif

endmodule

[dv/tb_period_to_engine_speed.sv]
// ----------------------------------------------------------------------------
// tb_period_to_engine_speed: self-checking bench for the engine speed block
// Drives captured periods through the valid/ready input and predicts the
// coarse period and the five speed values under changing enable and cylinder
// settings. Results are checked in order against the predictor. Both sides
// idle at random, and the receiver holds off once to back up the pipeline.
// ----------------------------------------------------------------------------
module tb_period_to_engine_speed;
  import pts_pkg::*;

  // bench timing
  localparam int SETTLE_CYCLES = 36;   // pipeline latency plus margin
  localparam int HOLD_CYCLES   = 90;   // long receiver hold-off, fills the chain
  localparam int IDLE_LIMIT    = 3000; // cycles without any handshake
  localparam int ITEMS_PER_PHASE = 90;
  localparam int PRINT_LIMIT   = 30;

  // constants of the speed formula, as the bench sees them
  localparam int unsigned TICKS_SAT_FROM = 32'd8388416;
  localparam int unsigned TICKS_HALF     = 32'd64;
  localparam int unsigned SPEED_NUM      = 32'd37500000;
  localparam int unsigned RAW_CAP        = 32'd65535;
  localparam int unsigned BDC_CAP        = 32'd8000;
  localparam int unsigned FINE_CAP       = 32'd32000;
  localparam int unsigned LIMITED_CAP    = 32'd7500;

  localparam logic [31:0] CORNER_PERIODS [19] = '{
    32'd0, 32'd63, 32'd64, 32'd127, 32'd128, 32'd191, 32'd192,
    32'd4700, 32'd18700, 32'd1000, 32'd100000, 32'd2000000,
    32'd8388415, 32'd8388416, 32'd8388417, 32'h8000_0000,
    32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF
  };

  typedef struct packed {
    logic [COARSE_W-1:0] coarse;
    logic [RAW_W-1:0]    raw;
    logic [RPM_W-1:0]    rpm;
    logic [RPM_W-1:0]    bdc;
    logic [FINE_W-1:0]   fine;
    logic [RPM_W-1:0]    limited;
  } speed_set_t;

  // predictor and in-order checker
  class speed_scoreboard;
    bit                 enable;
    logic [CYL_W-1:0]   cylinders;
    speed_set_t         speeds_due[$];
    int unsigned        errors;
    int unsigned        checked;
    int unsigned        periods_taken;

    function new();
      enable    = 1'b1;
      cylinders = CYL_RESET;
      errors    = 0;
      checked   = 0;
      periods_taken = 0;
    endfunction

    function void set_config(bit en, logic [CYL_W-1:0] cyl);
      enable    = en;
      cylinders = cyl;
    endfunction

    function int unsigned pending();
      return speeds_due.size();
    endfunction

    function speed_set_t expected_speeds(logic [PERIOD_W-1:0] period);
      speed_set_t  s;
      int unsigned coarse;
      int unsigned denom;
      int unsigned raw;
      int unsigned rpm;
      int unsigned half;
      raw = 0;
      rpm = 0;
      half = 0;
      // round to 128-tick units, saturate long periods
      if (period <= TICKS_SAT_FROM) coarse = (period + TICKS_HALF) >> 7;
      else coarse = RAW_CAP;
      s = '0;
      s.coarse = coarse[COARSE_W-1:0];
      // zero coarse period or zero cylinders leaves every speed at zero
      if (coarse != 0 && cylinders != 0) begin
        denom = coarse * cylinders;
        raw   = SPEED_NUM / denom;
        if (raw > RAW_CAP) raw = RAW_CAP;
        rpm  = raw >> 3;
        half = raw >> 1;
        s.raw     = raw[RAW_W-1:0];
        s.rpm     = rpm[RPM_W-1:0];
        s.bdc     = (rpm > BDC_CAP) ? BDC_CAP[RPM_W-1:0] : rpm[RPM_W-1:0];
        s.fine    = (half > FINE_CAP) ? FINE_CAP[FINE_W-1:0] : half[FINE_W-1:0];
        s.limited = (rpm > LIMITED_CAP) ? LIMITED_CAP[RPM_W-1:0] : rpm[RPM_W-1:0];
      end
      return s;
    endfunction

    function void note_period(logic [PERIOD_W-1:0] period);
      periods_taken++;
      if (enable) speeds_due.push_back(expected_speeds(period));
    endfunction

    task report_mismatch(string what, longint unsigned got, longint unsigned want);
      errors++;
      if (errors <= PRINT_LIMIT)
        $display("[%0t] mismatch: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    task check_speeds(speed_set_t got);
      speed_set_t want;
      if (speeds_due.size() == 0) begin
        report_mismatch("result with no request pending, coarse", got.coarse, 0);
      end else begin
        want = speeds_due.pop_front();
        checked++;
        if (got.coarse !== want.coarse)
          report_mismatch("period_coarse", got.coarse, want.coarse);
        if (got.raw !== want.raw) report_mismatch("speed_raw", got.raw, want.raw);
        if (got.rpm !== want.rpm) report_mismatch("speed_rpm", got.rpm, want.rpm);
        if (got.bdc !== want.bdc) report_mismatch("speed_bdc", got.bdc, want.bdc);
        if (got.fine !== want.fine) report_mismatch("speed_fine", got.fine, want.fine);
        if (got.limited !== want.limited)
          report_mismatch("speed_limited", got.limited, want.limited);
      end
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [PERIOD_W-1:0]   period_ticks;
  logic                  out_valid;
  logic                  out_ready;
  logic [COARSE_W-1:0]   period_coarse;
  logic [RAW_W-1:0]      speed_raw;
  logic [RPM_W-1:0]      speed_rpm;
  logic [RPM_W-1:0]      speed_bdc;
  logic [FINE_W-1:0]     speed_fine;
  logic [RPM_W-1:0]      speed_limited;

  speed_scoreboard sb = new();

  int unsigned tx_idle_pct = 25;
  int unsigned rx_idle_pct = 25;
  bit          hold_request = 1'b0;
  int unsigned quiet_cycles = 0;

  always #4 clk = ~clk;

  period_to_engine_speed dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .period_ticks  (period_ticks),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .period_coarse (period_coarse),
    .speed_raw     (speed_raw),
    .speed_rpm     (speed_rpm),
    .speed_bdc     (speed_bdc),
    .speed_fine    (speed_fine),
    .speed_limited (speed_limited)
  );

  // watch both handshakes, feed the scoreboard, guard against a hang
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_period(period_ticks);
      if (out_valid && out_ready)
        sb.check_speeds({period_coarse, speed_raw, speed_rpm, speed_bdc, speed_fine,
                         speed_limited});
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("[%0t] timeout: no request moved for %0d cycles", $realtime, IDLE_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // receiver: short random stalls, one long hold-off on request
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        stall_left   = HOLD_CYCLES;
        hold_request = 1'b0;
      end else if (stall_left == 0 && rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct)
      begin
        stall_left = $urandom_range(1, 3);
      end
      out_ready <= rst ? 1'b0 : (stall_left == 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // write both registers back to back; the block is idle here
  task automatic write_config(input bit en, input logic [CYL_W-1:0] cyl);
    cfg_write <= 1'b1;
    cfg_index <= REG_CALC_ENABLE;
    cfg_data  <= {{(CFG_DATA_W-1){1'b0}}, en};
    @(posedge clk);
    cfg_index <= REG_CYLINDER_COUNT;
    cfg_data  <= cyl;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.set_config(en, cyl);
  endtask

  // offer one period and hold it until taken, then maybe idle a little
  task automatic send_period(input logic [PERIOD_W-1:0] p);
    in_valid     <= 1'b1;
    period_ticks <= p;
    do @(posedge clk); while (!in_ready);
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // wait for every expected result, then let a disabled tail flush out
  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // period mix aimed at rounding edges, clamps and saturation
  function automatic logic [PERIOD_W-1:0] rand_period();
    logic [PERIOD_W-1:0] p;
    case ($urandom_range(0, 6))
      0: p = $urandom;
      1: p = $urandom_range(0, 255);
      2: p = $urandom_range(256, 30000);
      3: p = $urandom_range(30000, 400000);
      4: p = $urandom_range(400000, TICKS_SAT_FROM);
      5: p = TICKS_SAT_FROM - 100 + $urandom_range(0, 200);
      default: p = ($urandom_range(0, 65534) << 7) + 63 + $urandom_range(0, 1);
    endcase
    return p;
  endfunction

  initial begin
    logic [CYL_W-1:0] cyl;
    rst          <= 1'b1;
    cfg_write    <= 1'b0;
    cfg_index    <= REG_CALC_ENABLE;
    cfg_data     <= '0;
    in_valid     <= 1'b0;
    period_ticks <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // corner periods with the reset settings
    foreach (CORNER_PERIODS[i]) send_period(CORNER_PERIODS[i]);
    drain_pipe();

    // no cylinders: speeds forced to zero, coarse still reported
    write_config(1'b1, 4'd0);
    send_period(32'd0);
    send_period(32'd192);
    send_period(32'd18700);
    drain_pipe();

    // computation off: requests taken, nothing comes out
    write_config(1'b0, 4'd4);
    repeat (12) send_period(rand_period());
    drain_pipe();

    // widest cylinder count on small and saturated periods
    write_config(1'b1, 4'd15);
    send_period(32'd64);
    send_period(32'd4700);
    send_period(32'hFFFF_FFFF);
    drain_pipe();

    // random phases over cylinder counts and idling mixes
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: cyl = 4'd1;
        1: cyl = 4'd12;
        2: cyl = 4'd13;
        3: cyl = 4'd15;
        4: cyl = 4'd8;
        5: cyl = 4'd2;
        6: cyl = 4'd14;
        7: cyl = 4'd3;
        8: cyl = 4'd6;
        default: cyl = CYL_W'($urandom_range(1, 15));
      endcase
      tx_idle_pct = (ph % 3 == 1) ? 0 : 25;
      rx_idle_pct = (ph % 4 == 2) ? 0 : 30;
      if (ph == 9) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      write_config(1'b1, cyl);
      if (ph == 2) begin
        // back the pipeline up while periods keep coming
        tx_idle_pct  = 0;
        hold_request = 1'b1;
      end
      repeat (ITEMS_PER_PHASE) send_period(rand_period());
      drain_pipe();
      if (ph == 5) begin
        write_config(1'b0, CYL_W'($urandom_range(0, 15)));
        repeat (20) send_period(rand_period());
        drain_pipe();
      end
    end

    $display("Drove %0d periods and checked %0d speed results", sb.periods_taken, sb.checked);
    $display("Covered zero and high cylinder counts, computation on and off, long receiver hold-off");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[files.f]
hdl/pts_pkg.sv
hdl/pts_front.sv
hdl/pts_cell.sv
hdl/pts_back.sv
hdl/period_to_engine_speed.sv
dv/tb_period_to_engine_speed.sv
